// ----- hw/rtl/pdcr_pkg.sv -----
// Shared constants for the phase derivative complex rotator.
// No dependencies; used by pdcr_hstep and phase_derivative_complex_rotator.
package pdcr_pkg;

  // 1.0 in Q30
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  // half of a quadrant in units of 2^-32 turn
  localparam logic [29:0] OCTANT_Q30 = 30'h2000_0000;
  // 1/(2*pi) in Q0.64
  localparam logic [63:0] INV_2PI    = 64'h28BE_60DB_9391_054A;
  // pi in Q2.30
  localparam logic [31:0] PI_Q30     = 32'hC90F_DAA2;

  // reciprocal scale for the constant divides in the series
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_W     = 37;

  // ceil(2^37 / k): exact floor division for 30-bit dividends, k <= 90
  localparam logic [RECIP_W-1:0] RECIP_SIN [4] = '{
    37'(((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72),
    37'(((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42),
    37'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20),
    37'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6)
  };
  localparam logic [RECIP_W-1:0] RECIP_COS [5] = '{
    37'(((64'd1 << RECIP_SHIFT) + 64'd89) / 64'd90),
    37'(((64'd1 << RECIP_SHIFT) + 64'd55) / 64'd56),
    37'(((64'd1 << RECIP_SHIFT) + 64'd29) / 64'd30),
    37'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12),
    37'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd2)
  };

endpackage

// ----- hw/rtl/pdcr_hstep.sv -----
// One Horner step of the sine/cosine series: q = ((x2*h)>>30) / k.
// Two register stages (multiply, reciprocal multiply); uses pdcr_pkg.
module pdcr_hstep #(
  parameter logic [pdcr_pkg::RECIP_W-1:0] RECIP = pdcr_pkg::RECIP_COS[0]
) (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] x2_i,
  input  logic [30:0] h_i,
  output logic [29:0] q_o
);

  logic [60:0] mprod;
  logic [29:0] m_r;
  logic [66:0] dprod;
  logic [29:0] q_r;

  // x2*h in Q60, back to Q30 (result stays below 2^30)
  assign mprod = {31'b0, x2_i} * {30'b0, h_i};

  // floor divide by k through the rounded-up reciprocal
  assign dprod = {37'b0, m_r} * {30'b0, RECIP};

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= mprod[59:30];
      q_r <= dprod[66:pdcr_pkg::RECIP_SHIFT];
    end
  end

  assign q_o = q_r;

endmodule

// ----- hw/rtl/phase_derivative_complex_rotator.sv -----
// Top level of the phase derivative complex rotator pipeline.
// Depends on pdcr_pkg and pdcr_hstep.
//
// Usage:
//   in_*  : stream of beats {re_in, im_in, phase_rate}; one beat per item.
//   out_* : stream of beats {re_out, im_out}; exactly one per input beat,
//           in order.
//   cfg_* : write of zone_thickness, taken on any edge with cfg_wr_en high and rst_n high;
//           write only while the pipeline is empty.
// Each item computes p = z*d, reduces p to a turn angle, evaluates sin/cos
// by octant series, and rotates the sample by d*(-sin p + j cos p).
// Throughput: one beat per cycle while the skid register is empty. Path to
// out_tvalid: stages 0..21 of arithmetic (stage 0 is loaded at the accepting
// edge; the ten-stage series evaluation is the longest part), then the
// output register.
// Reset clears all valid bits and sets zone_thickness to 0.
// Stall: when out_tready is low the output register holds its beat; the
// next finished beat goes to a one-entry skid register, and the whole
// pipeline and in_tready stop only while that skid register is full.
module phase_derivative_complex_rotator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // re_in[23:0], im_in[47:24], phase_rate[79:48]
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // re_out[55:0], im_out[111:56]
  output logic [111:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data
);

  localparam int NST = 22;

  // ---------------- control ----------------
  logic               en;
  logic [NST-1:0]     v_r;
  logic               out_v_r;
  logic               skid_v_r;
  logic signed [31:0] z_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_r <= '0;
    end else if (cfg_wr_en) begin
      z_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_tvalid};
    end
  end

  // ---------------- carried fields ----------------
  logic signed [23:0] re_r [0:17];
  logic signed [23:0] im_r [0:17];
  logic signed [31:0] d_r  [0:16];
  logic [1:0]         qd_r [4:15];
  logic               sw_r [4:15];
  logic [29:0]        x_r  [4:13];
  logic [29:0]        x2_r [5:13];

  always_ff @(posedge clk) begin
    if (en) begin
      re_r[0] <= in_tdata[23:0];
      im_r[0] <= in_tdata[47:24];
      d_r[0]  <= in_tdata[79:48];
      for (int k = 1; k < 18; k++) begin
        re_r[k] <= re_r[k-1];
        im_r[k] <= im_r[k-1];
      end
      for (int k = 1; k < 17; k++) begin
        d_r[k] <= d_r[k-1];
      end
      for (int k = 5; k < 16; k++) begin
        qd_r[k] <= qd_r[k-1];
        sw_r[k] <= sw_r[k-1];
      end
      for (int k = 5; k < 14; k++) begin
        x_r[k] <= x_r[k-1];
      end
      for (int k = 6; k < 14; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
    end
  end

  // ---------------- stages 0..3: phase and turn angle ----------------
  logic signed [63:0]  p_nxt, p_r;
  logic signed [31:0]  ph;
  logic signed [32:0]  ch_s, cl_s;
  logic signed [64:0]  hh_nxt, hl_nxt;
  logic [63:0]         lh_nxt, ll_nxt;
  logic [51:0]         hh1_r, hh2_r;
  logic signed [64:0]  hl_r;
  logic [63:0]         lh_r, ll1_r, ll2_r;
  logic [66:0]         mid_nxt, mid_r;
  logic [115:0]        tsum;
  logic [31:0]         t_r;

  // p = z*d, LSB 2^-52 rad
  assign p_nxt = $signed(z_r) * $signed(in_tdata[79:48]);

  // p * (1/2pi) as four 32-bit partial products
  assign ph     = p_r[63:32];
  assign ch_s   = {1'b0, pdcr_pkg::INV_2PI[63:32]};
  assign cl_s   = {1'b0, pdcr_pkg::INV_2PI[31:0]};
  assign hh_nxt = ph * ch_s;
  assign hl_nxt = ph * cl_s;
  assign lh_nxt = {32'b0, p_r[31:0]} * {32'b0, pdcr_pkg::INV_2PI[63:32]};
  assign ll_nxt = {32'b0, p_r[31:0]} * {32'b0, pdcr_pkg::INV_2PI[31:0]};

  // cross terms, then the total modulo one turn
  assign mid_nxt = {{2{hl_r[64]}}, hl_r} + {3'b0, lh_r};
  assign tsum    = {hh2_r, 64'b0} + {{17{mid_r[66]}}, mid_r, 32'b0} + {52'b0, ll2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      hh1_r <= hh_nxt[51:0];
      hl_r  <= hl_nxt;
      lh_r  <= lh_nxt;
      ll1_r <= ll_nxt;
      hh2_r <= hh1_r;
      mid_r <= mid_nxt;
      ll2_r <= ll1_r;
      t_r   <= tsum[115:84];
    end
  end

  // ---------------- stages 4..5: octant fold, radians, square ----------------
  logic [29:0] rr;
  logic        swap;
  logic [30:0] afold;
  logic [61:0] xprod;
  logic [59:0] x2prod;

  assign rr     = t_r[29:0];
  assign swap   = rr > pdcr_pkg::OCTANT_Q30;
  assign afold  = swap ? (pdcr_pkg::ONE_Q30 - {1'b0, rr}) : {1'b0, rr};
  assign xprod  = {32'b0, afold[29:0]} * {30'b0, pdcr_pkg::PI_Q30};
  assign x2prod = {30'b0, x_r[4]} * {30'b0, x_r[4]};

  always_ff @(posedge clk) begin
    if (en) begin
      qd_r[4] <= t_r[31:30];
      sw_r[4] <= swap;
      x_r[4]  <= xprod[60:31];
      x2_r[5] <= x2prod[59:30];
    end
  end

  // ---------------- stages 6..15: series ----------------
  logic [29:0] qs [4];
  logic [29:0] qc [5];

  for (genvar i = 0; i < 4; i++) begin : g_sin
    logic [30:0] h;
    if (i == 0) begin : g_first
      assign h = pdcr_pkg::ONE_Q30;
    end else begin : g_next
      assign h = pdcr_pkg::ONE_Q30 - {1'b0, qs[i-1]};
    end
    pdcr_hstep #(.RECIP(pdcr_pkg::RECIP_SIN[i])) u_step (
      .clk  (clk),
      .en   (en),
      .x2_i (x2_r[5+2*i]),
      .h_i  (h),
      .q_o  (qs[i])
    );
  end

  for (genvar i = 0; i < 5; i++) begin : g_cos
    logic [30:0] h;
    if (i == 0) begin : g_first
      assign h = pdcr_pkg::ONE_Q30;
    end else begin : g_next
      assign h = pdcr_pkg::ONE_Q30 - {1'b0, qc[i-1]};
    end
    pdcr_hstep #(.RECIP(pdcr_pkg::RECIP_COS[i])) u_step (
      .clk  (clk),
      .en   (en),
      .x2_i (x2_r[5+2*i]),
      .h_i  (h),
      .q_o  (qc[i])
    );
  end

  // final sine multiply, then one stage to line up with cosine
  logic [30:0] hs_fin;
  logic [60:0] sprod;
  logic [30:0] s14_r, s15_r;

  assign hs_fin = pdcr_pkg::ONE_Q30 - {1'b0, qs[3]};
  assign sprod  = {31'b0, x_r[13]} * {30'b0, hs_fin};

  always_ff @(posedge clk) begin
    if (en) begin
      s14_r <= sprod[60:30];
      s15_r <= s14_r;
    end
  end

  // ---------------- stage 16: quadrant signs ----------------
  logic [30:0]        craw, s_eff, c_eff;
  logic signed [31:0] sn_nxt, cs_nxt, sn_r, cs_r;

  assign craw  = pdcr_pkg::ONE_Q30 - {1'b0, qc[4]};
  assign s_eff = sw_r[15] ? craw : s15_r;
  assign c_eff = sw_r[15] ? s15_r : craw;

  always_comb begin
    case (qd_r[15])
      2'd0: begin
        sn_nxt = {1'b0, s_eff};
        cs_nxt = {1'b0, c_eff};
      end
      2'd1: begin
        sn_nxt = {1'b0, c_eff};
        cs_nxt = -$signed({1'b0, s_eff});
      end
      2'd2: begin
        sn_nxt = -$signed({1'b0, s_eff});
        cs_nxt = -$signed({1'b0, c_eff});
      end
      default: begin
        sn_nxt = -$signed({1'b0, c_eff});
        cs_nxt = {1'b0, s_eff};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= sn_nxt;
      cs_r <= cs_nxt;
    end
  end

  // ---------------- stage 17: A = -sin*d, B = cos*d ----------------
  logic signed [31:0] nsn;
  logic signed [63:0] a_nxt, b_nxt, a_r, b_r;

  assign nsn   = -sn_r;
  assign a_nxt = nsn * d_r[16];
  assign b_nxt = cs_r * d_r[16];

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  // ---------------- stages 18..19: sample products ----------------
  logic signed [31:0] ah, bh;
  logic signed [32:0] al, bl;
  logic signed [55:0] reah_r, imah_r, rebh_r, imbh_r;
  logic signed [56:0] real_r, imal_r, rebl_r, imbl_r;
  logic signed [87:0] rea_r, ima_r, reb_r, imb_r;

  assign ah = a_r[63:32];
  assign al = {1'b0, a_r[31:0]};
  assign bh = b_r[63:32];
  assign bl = {1'b0, b_r[31:0]};

  function automatic logic signed [87:0] join_pp(logic signed [55:0] hi,
                                                 logic signed [56:0] lo);
    join_pp = {hi, 32'b0} + {{31{lo[56]}}, lo};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      reah_r <= re_r[17] * ah;
      real_r <= re_r[17] * al;
      imah_r <= im_r[17] * ah;
      imal_r <= im_r[17] * al;
      rebh_r <= re_r[17] * bh;
      rebl_r <= re_r[17] * bl;
      imbh_r <= im_r[17] * bh;
      imbl_r <= im_r[17] * bl;
      rea_r  <= join_pp(reah_r, real_r);
      ima_r  <= join_pp(imah_r, imal_r);
      reb_r  <= join_pp(rebh_r, rebl_r);
      imb_r  <= join_pp(imbh_r, imbl_r);
    end
  end

  // ---------------- stages 20..21: sums, floor shift, saturate ----------------
  logic signed [87:0] sre_r, sim_r;
  logic [55:0]        ore_r, oim_r;

  function automatic logic [55:0] sat56(logic signed [87:0] v);
    logic [57:0] sh;
    sh = v[87:30];
    if (sh[57:55] == 3'b000 || sh[57:55] == 3'b111) begin
      sat56 = sh[55:0];
    end else if (sh[57]) begin
      sat56 = {1'b1, 55'b0};
    end else begin
      sat56 = {1'b0, {55{1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      sre_r <= rea_r - imb_r;
      sim_r <= reb_r + ima_r;
      ore_r <= sat56(sre_r);
      oim_r <= sat56(sim_r);
    end
  end

  // ---------------- output register and skid ----------------
  logic [111:0] out_d_r, skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (out_tready || !out_v_r) begin
      out_v_r <= v_r[NST-1];
    end else if (v_r[NST-1]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_r <= skid_d_r;
      end
    end else if (out_tready || !out_v_r) begin
      out_d_r <= {oim_r, ore_r};
    end else begin
      skid_d_r <= {oim_r, ore_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // ---------------- assertions ----------------
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat while the output register is empty");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_tready)
    else $error("input accepted while skid register is full");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready && v_r[NST-1]))
    else $error("skid filled without a stalled output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !skid_v_r && (v_r == '0))
    else $error("valid state not cleared by reset");

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for phase_derivative_complex_rotator: directed and random samples.
// Depends on pdcr_pkg and the rotator RTL; expected results come from a built-in predictor.
module testbench;

  // packed from the top down: im in the high half, re in the low half
  typedef struct packed {
    logic [55:0] im;
    logic [55:0] re;
  } rot_beat_t;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // re_in[23:0], im_in[47:24], phase_rate[79:48]
  logic [79:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // re_out[55:0], im_out[111:56]
  logic [111:0] out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [31:0]  cfg_wr_data = '0;

  logic signed [31:0] zone_thk = '0;
  rot_beat_t rot_expected[$];
  int sent_items = 0;
  int checked_beats = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int cfg_writes = 0;

  phase_derivative_complex_rotator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sign-extend to the wide accumulator
  function automatic logic signed [127:0] wide(longint v);
    return {{64{v[63]}}, v};
  endfunction

  // sin/cos in Q30 of an angle within the first octant (units 2^-32 turn)
  function automatic void octant_trig(longint unsigned a, output longint unsigned s,
                                      output longint unsigned c);
    longint unsigned ks[4] = '{72, 42, 20, 6};
    longint unsigned kc[5] = '{90, 56, 30, 12, 2};
    longint unsigned one = 64'd1 << 30;
    longint unsigned x, x2, h;
    x  = (a * {32'd0, pdcr_pkg::PI_Q30}) >> 31;
    x2 = (x * x) >> 30;
    h = one;
    for (int i = 0; i < 4; i++) h = one - ((x2 * h) >> 30) / ks[i];
    s = (x * h) >> 30;
    h = one;
    for (int i = 0; i < 5; i++) h = one - ((x2 * h) >> 30) / kc[i];
    c = h;
  endfunction

  // floor shift by 30, then clamp to 56-bit signed
  function automatic logic [55:0] shift_clamp(logic signed [127:0] v);
    logic signed [127:0] sh;
    logic signed [127:0] top;
    logic signed [127:0] bot;
    sh  = v >>> 30;
    top = (128'sd1 <<< 55) - 128'sd1;
    bot = -(128'sd1 <<< 55);
    if (sh > top) return top[55:0];
    if (sh < bot) return bot[55:0];
    return sh[55:0];
  endfunction

  // derivative of the thickness rotation applied to one sample
  function automatic rot_beat_t predict_rotation(logic signed [23:0] re,
                                                 logic signed [23:0] im,
                                                 logic signed [31:0] d);
    longint p, sn, cs, coef_a, coef_b;
    logic signed [127:0] turn_prod;
    logic [31:0] t;
    logic [29:0] r;
    longint unsigned s, c;
    rot_beat_t res;
    p = longint'(zone_thk) * longint'(d);
    turn_prod = wide(p) * $signed({64'd0, pdcr_pkg::INV_2PI});
    t = turn_prod[115:84];
    r = t[29:0];
    if (r > pdcr_pkg::OCTANT_Q30) octant_trig((64'd1 << 30) - r, c, s);
    else octant_trig({34'd0, r}, s, c);
    case (t[31:30])
      2'd0: begin sn = s; cs = c; end
      2'd1: begin sn = c; cs = -longint'(s); end
      2'd2: begin sn = -longint'(s); cs = -longint'(c); end
      default: begin sn = -longint'(c); cs = s; end
    endcase
    coef_a = -sn * longint'(d);
    coef_b = cs * longint'(d);
    res.re = shift_clamp(wide(re) * wide(coef_a) - wide(im) * wide(coef_b));
    res.im = shift_clamp(wide(re) * wide(coef_b) + wide(im) * wide(coef_a));
    return res;
  endfunction

  // one input beat; returns at the edge where it is taken
  task automatic send_sample(logic [23:0] re, logic [23:0] im, logic [31:0] d);
    logic rdy;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, im, re};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    rot_expected.push_back(predict_rotation(re, im, d));
    sent_items++;
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
    wait (rot_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_thickness(logic [31:0] z);
    end_stream();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= z;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    zone_thk = z;
    cfg_writes++;
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'h00000000;
      3: return 32'($urandom_range(0, 4095));
      4: return 32'($signed(-$urandom_range(0, 4095)));
      default: return $urandom;
    endcase
  endfunction

  // response side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    rot_beat_t want;
    rot_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      checked_beats++;
      if (rot_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat re=%h im=%h", got.re, got.im);
      end else begin
        want = rot_expected.pop_front();
        if (got.re !== want.re || got.im !== want.im) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch z=%0d: re exp %h got %h, im exp %h got %h",
                     zone_thk, want.re, got.re, want.im, got.im);
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_reset_thickness();
    // reset value of the thickness gives zero phase
    send_sample(24'h100000, 24'h000000, 32'h00000100);
    send_sample(24'h7FFFFF, 24'h800000, 32'h80000000);
    send_sample(24'h123456, 24'h654321, 32'h00000000);
  endtask

  task automatic test_directed();
    logic [31:0] zs[5] = '{32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                           32'h00123456};
    foreach (zs[i]) begin
      write_thickness(zs[i]);
      send_sample(24'h800000, 24'h800000, 32'h80000000);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 32'h7FFFFFFF);
      send_sample(24'h7FFFFF, 24'h800000, 32'h00000000);
      send_sample(24'h000001, 24'hFFFFFF, 32'h0000ABCD);
    end
  endtask

  task automatic test_random_phases();
    int idle[4]  = '{0, 57, 0, 26};
    int stall[4] = '{0, 0, 57, 26};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle[ph];
      recv_stall_pct = stall[ph];
      for (int k = 0; k < 5; k++) begin
        write_thickness(pick_word());
        repeat ($urandom_range(30, 70)) send_sample(pick_sample(), pick_sample(), pick_word());
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_thickness($urandom);
    hold_cycles = 200;
    repeat (120) send_sample(pick_sample(), pick_sample(), pick_word());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_thickness();
    test_directed();
    test_random_phases();
    test_backpressure();
    end_stream();
    $display("covered %0d samples, %0d thickness writes, %0d results checked",
             sent_items, cfg_writes, checked_beats);
    $display("idle and stall mixes plus one long output hold-off were exercised");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
